// File: design/r16dbc_pkg.sv
// Shared types and constants for the 16-bit decode and branch control block.
// Holds opcode, condition and ALU code constants plus the decode control struct.
// No dependencies.
package r16dbc_pkg;

    // Major opcodes, instruction bits 15..12
    localparam logic [3:0] OP_REG   = 4'd0;
    localparam logic [3:0] OP_ANDI  = 4'd1;
    localparam logic [3:0] OP_ORI   = 4'd2;
    localparam logic [3:0] OP_XORI  = 4'd3;
    localparam logic [3:0] OP_MEM   = 4'd4;
    localparam logic [3:0] OP_ADDI  = 4'd5;
    localparam logic [3:0] OP_SHIFT = 4'd8;
    localparam logic [3:0] OP_SUBI  = 4'd9;
    localparam logic [3:0] OP_CMPI  = 4'd11;
    localparam logic [3:0] OP_BCOND = 4'd12;
    localparam logic [3:0] OP_MOVI  = 4'd13;
    localparam logic [3:0] OP_LUI   = 4'd15;

    // Op extensions for register forms, instruction bits 7..4
    localparam logic [3:0] EXT_AND = 4'd1;
    localparam logic [3:0] EXT_OR  = 4'd2;
    localparam logic [3:0] EXT_XOR = 4'd3;
    localparam logic [3:0] EXT_ADD = 4'd5;
    localparam logic [3:0] EXT_SUB = 4'd9;
    localparam logic [3:0] EXT_CMP = 4'd11;
    localparam logic [3:0] EXT_MOV = 4'd13;

    // Op extensions under the memory/jump opcode
    localparam logic [3:0] EXT_LOAD  = 4'd0;
    localparam logic [3:0] EXT_STOR  = 4'd4;
    localparam logic [3:0] EXT_JAL   = 4'd8;
    localparam logic [3:0] EXT_JCOND = 4'd12;

    // Shift ops, instruction bits 7..5
    localparam logic [2:0] SH_LSHI  = 3'd0;
    localparam logic [2:0] SH_ASHUI = 3'd1;
    localparam logic [2:0] SH_LSH   = 3'd2;
    localparam logic [2:0] SH_ASHU  = 3'd3;

    // Condition codes
    localparam logic [3:0] CC_EQ = 4'd0;
    localparam logic [3:0] CC_NE = 4'd1;
    localparam logic [3:0] CC_CS = 4'd2;
    localparam logic [3:0] CC_CC = 4'd3;
    localparam logic [3:0] CC_GT = 4'd6;
    localparam logic [3:0] CC_LE = 4'd7;
    localparam logic [3:0] CC_LT = 4'd12;
    localparam logic [3:0] CC_GE = 4'd13;

    // Condition rank within the branch ALU code sequence
    localparam logic [2:0] RANK_EQ = 3'd0;
    localparam logic [2:0] RANK_NE = 3'd1;
    localparam logic [2:0] RANK_GE = 3'd2;
    localparam logic [2:0] RANK_CS = 3'd3;
    localparam logic [2:0] RANK_CC = 3'd4;
    localparam logic [2:0] RANK_GT = 3'd5;
    localparam logic [2:0] RANK_LE = 3'd6;
    localparam logic [2:0] RANK_LT = 3'd7;

    // ALU codes
    localparam logic [5:0] ALU_NONE       = 6'd0;
    localparam logic [5:0] ALU_ADD        = 6'd1;
    localparam logic [5:0] ALU_ADDI       = 6'd2;
    localparam logic [5:0] ALU_SUB        = 6'd3;
    localparam logic [5:0] ALU_SUBI       = 6'd4;
    localparam logic [5:0] ALU_CMP        = 6'd5;
    localparam logic [5:0] ALU_CMPI       = 6'd6;
    localparam logic [5:0] ALU_AND        = 6'd7;
    localparam logic [5:0] ALU_ANDI       = 6'd8;
    localparam logic [5:0] ALU_OR         = 6'd9;
    localparam logic [5:0] ALU_ORI        = 6'd10;
    localparam logic [5:0] ALU_XOR        = 6'd11;
    localparam logic [5:0] ALU_XORI       = 6'd12;
    localparam logic [5:0] ALU_MOV        = 6'd13;
    localparam logic [5:0] ALU_MOVI       = 6'd14;
    localparam logic [5:0] ALU_LSH        = 6'd15;
    localparam logic [5:0] ALU_LSHI       = 6'd16;
    localparam logic [5:0] ALU_ASHU       = 6'd17;
    localparam logic [5:0] ALU_ASHUI      = 6'd18;
    localparam logic [5:0] ALU_LUI        = 6'd19;
    localparam logic [5:0] ALU_LOAD       = 6'd20;
    localparam logic [5:0] ALU_STOR       = 6'd21;
    localparam logic [5:0] ALU_BCOND_BASE = 6'd22;
    localparam logic [5:0] ALU_JCOND_BASE = 6'd30;
    localparam logic [5:0] ALU_JAL        = 6'd38;
    localparam logic [5:0] ALU_NOP        = 6'd39;

    // Mux select bits
    localparam logic [3:0] MUX_M1 = 4'b0001;
    localparam logic [3:0] MUX_M2 = 4'b0010;
    localparam logic [3:0] MUX_M3 = 4'b0100;
    localparam logic [3:0] MUX_M4 = 4'b1000;

    typedef enum logic [1:0] {
        PC_SEL_INC  = 2'd0,
        PC_SEL_DISP = 2'd1,
        PC_SEL_TGT  = 2'd2
    } pc_sel_t;

    typedef struct packed {
        logic [5:0] alu_code;
        logic [3:0] mux_selects;
        logic       reg_write;
        logic       reg_read;
        logic       mem_read;
        logic       mem_write;
        pc_sel_t    pc_sel;
    } dec_ctrl_t;

endpackage

// File: design/r16dbc_decode.sv
// Instruction decoder: control strobes, ALU code and counter source select.
// Purely combinational; uses r16dbc_pkg.
module r16dbc_decode (
    input  logic [15:0]            instruction,
    input  logic [3:0]             status_flags,
    output r16dbc_pkg::dec_ctrl_t  ctrl
);

    logic [3:0] op;
    logic [3:0] cc;
    logic [3:0] ext;
    logic [2:0] sh;
    logic [3:0] m1i;
    logic       flag_z;
    logic       flag_n;
    logic       flag_c;
    logic       cond_known;
    logic       cond_taken;
    logic [2:0] cond_rank;

    assign op     = instruction[15:12];
    assign cc     = instruction[11:8];
    assign ext    = instruction[7:4];
    assign sh     = instruction[7:5];
    assign m1i    = instruction[7] ? 4'b0000 : r16dbc_pkg::MUX_M1;
    assign flag_z = status_flags[3];
    assign flag_n = status_flags[1];
    assign flag_c = status_flags[0];

    // Condition evaluation, shared by Jcond and Bcond
    always_comb begin
        cond_known = 1'b1;
        cond_taken = 1'b0;
        cond_rank  = r16dbc_pkg::RANK_LT;
        case (cc)
            r16dbc_pkg::CC_EQ: begin
                cond_taken = flag_z;
                cond_rank  = r16dbc_pkg::RANK_EQ;
            end
            r16dbc_pkg::CC_NE: begin
                cond_taken = !flag_z;
                cond_rank  = r16dbc_pkg::RANK_NE;
            end
            r16dbc_pkg::CC_CS: begin
                cond_taken = flag_c;
                cond_rank  = r16dbc_pkg::RANK_CS;
            end
            r16dbc_pkg::CC_CC: begin
                cond_taken = !flag_c;
                cond_rank  = r16dbc_pkg::RANK_CC;
            end
            r16dbc_pkg::CC_GT: begin
                cond_taken = flag_n;
                cond_rank  = r16dbc_pkg::RANK_GT;
            end
            r16dbc_pkg::CC_LE: begin
                cond_taken = !flag_n;
                cond_rank  = r16dbc_pkg::RANK_LE;
            end
            r16dbc_pkg::CC_LT: begin
                cond_taken = !flag_n && !flag_z;
                cond_rank  = r16dbc_pkg::RANK_LT;
            end
            r16dbc_pkg::CC_GE: begin
                cond_taken = flag_z || flag_n;
                cond_rank  = r16dbc_pkg::RANK_GE;
            end
            default: begin
                cond_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        ctrl = '{alu_code: r16dbc_pkg::ALU_NONE, mux_selects: 4'b0000,
                 reg_write: 1'b0, reg_read: 1'b0, mem_read: 1'b0, mem_write: 1'b0,
                 pc_sel: r16dbc_pkg::PC_SEL_INC};
        if (instruction == 16'h0000) begin
            ctrl.alu_code = r16dbc_pkg::ALU_NOP;
        end else if (op == r16dbc_pkg::OP_REG) begin
            ctrl.reg_write   = 1'b1;
            ctrl.reg_read    = 1'b1;
            ctrl.mux_selects = r16dbc_pkg::MUX_M2 | r16dbc_pkg::MUX_M3;
            case (ext)
                r16dbc_pkg::EXT_ADD: ctrl.alu_code = r16dbc_pkg::ALU_ADD;
                r16dbc_pkg::EXT_SUB: ctrl.alu_code = r16dbc_pkg::ALU_SUB;
                r16dbc_pkg::EXT_AND: ctrl.alu_code = r16dbc_pkg::ALU_AND;
                r16dbc_pkg::EXT_CMP: begin
                    ctrl.alu_code  = r16dbc_pkg::ALU_CMP;
                    ctrl.reg_write = 1'b0;
                end
                r16dbc_pkg::EXT_OR:  ctrl.alu_code = r16dbc_pkg::ALU_OR;
                r16dbc_pkg::EXT_XOR: ctrl.alu_code = r16dbc_pkg::ALU_XOR;
                r16dbc_pkg::EXT_MOV: ctrl.alu_code = r16dbc_pkg::ALU_MOV;
                default: begin
                    ctrl.reg_write   = 1'b0;
                    ctrl.reg_read    = 1'b0;
                    ctrl.mux_selects = 4'b0000;
                end
            endcase
        end else if (op inside {r16dbc_pkg::OP_ADDI, r16dbc_pkg::OP_SUBI,
                                r16dbc_pkg::OP_ANDI, r16dbc_pkg::OP_CMPI,
                                r16dbc_pkg::OP_ORI, r16dbc_pkg::OP_XORI,
                                r16dbc_pkg::OP_MOVI}) begin
            ctrl.reg_write   = (op != r16dbc_pkg::OP_CMPI);
            ctrl.reg_read    = 1'b1;
            ctrl.mux_selects = m1i | r16dbc_pkg::MUX_M3;
            if (op inside {r16dbc_pkg::OP_ORI, r16dbc_pkg::OP_XORI,
                           r16dbc_pkg::OP_MOVI}) begin
                ctrl.mux_selects = ctrl.mux_selects | r16dbc_pkg::MUX_M4;
            end
            case (op)
                r16dbc_pkg::OP_ADDI: ctrl.alu_code = r16dbc_pkg::ALU_ADDI;
                r16dbc_pkg::OP_SUBI: ctrl.alu_code = r16dbc_pkg::ALU_SUBI;
                r16dbc_pkg::OP_ANDI: ctrl.alu_code = r16dbc_pkg::ALU_ANDI;
                r16dbc_pkg::OP_CMPI: ctrl.alu_code = r16dbc_pkg::ALU_CMPI;
                r16dbc_pkg::OP_ORI:  ctrl.alu_code = r16dbc_pkg::ALU_ORI;
                r16dbc_pkg::OP_XORI: ctrl.alu_code = r16dbc_pkg::ALU_XORI;
                default:             ctrl.alu_code = r16dbc_pkg::ALU_MOVI;
            endcase
        end else if (op == r16dbc_pkg::OP_SHIFT) begin
            if (sh inside {r16dbc_pkg::SH_LSHI, r16dbc_pkg::SH_ASHUI,
                           r16dbc_pkg::SH_LSH, r16dbc_pkg::SH_ASHU}) begin
                ctrl.reg_write   = 1'b1;
                ctrl.reg_read    = 1'b1;
                ctrl.mux_selects = m1i | r16dbc_pkg::MUX_M3 | r16dbc_pkg::MUX_M4;
                if (sh[1]) begin
                    ctrl.mux_selects = ctrl.mux_selects | r16dbc_pkg::MUX_M2;
                end
                case (sh)
                    r16dbc_pkg::SH_LSHI:  ctrl.alu_code = r16dbc_pkg::ALU_LSHI;
                    r16dbc_pkg::SH_ASHUI: ctrl.alu_code = r16dbc_pkg::ALU_ASHUI;
                    r16dbc_pkg::SH_LSH:   ctrl.alu_code = r16dbc_pkg::ALU_LSH;
                    default:              ctrl.alu_code = r16dbc_pkg::ALU_ASHU;
                endcase
            end
        end else if (op == r16dbc_pkg::OP_MEM) begin
            case (ext)
                r16dbc_pkg::EXT_LOAD: begin
                    ctrl.alu_code    = r16dbc_pkg::ALU_LOAD;
                    ctrl.reg_write   = 1'b1;
                    ctrl.mem_read    = 1'b1;
                    ctrl.mux_selects = m1i | r16dbc_pkg::MUX_M2;
                end
                r16dbc_pkg::EXT_STOR: begin
                    ctrl.alu_code    = r16dbc_pkg::ALU_STOR;
                    ctrl.reg_read    = 1'b1;
                    ctrl.mem_write   = 1'b1;
                    ctrl.mux_selects = m1i | r16dbc_pkg::MUX_M2;
                end
                r16dbc_pkg::EXT_JAL: begin
                    ctrl.alu_code    = r16dbc_pkg::ALU_JAL;
                    ctrl.reg_write   = 1'b1;
                    ctrl.reg_read    = 1'b1;
                    ctrl.mux_selects = m1i | r16dbc_pkg::MUX_M2;
                    ctrl.pc_sel      = r16dbc_pkg::PC_SEL_TGT;
                end
                r16dbc_pkg::EXT_JCOND: begin
                    if (cond_known) begin
                        ctrl.alu_code = r16dbc_pkg::ALU_JCOND_BASE + 6'(cond_rank);
                        ctrl.reg_read = 1'b1;
                        if (cond_taken) begin
                            ctrl.pc_sel = r16dbc_pkg::PC_SEL_TGT;
                        end
                    end
                end
                default: begin
                    ctrl.alu_code = r16dbc_pkg::ALU_NONE;
                end
            endcase
        end else if (op == r16dbc_pkg::OP_BCOND) begin
            if (cond_known) begin
                ctrl.alu_code = r16dbc_pkg::ALU_BCOND_BASE + 6'(cond_rank);
                if (cond_taken) begin
                    ctrl.pc_sel = r16dbc_pkg::PC_SEL_DISP;
                end
            end
        end else if (op == r16dbc_pkg::OP_LUI) begin
            ctrl.alu_code    = r16dbc_pkg::ALU_LUI;
            ctrl.reg_write   = 1'b1;
            ctrl.mux_selects = r16dbc_pkg::MUX_M1 | r16dbc_pkg::MUX_M3 | r16dbc_pkg::MUX_M4;
        end
    end

endmodule

// File: design/risc16_decode_branch_control.sv
// Instruction decode and program counter unit, two-register pipeline.
// Uses r16dbc_pkg and r16dbc_decode.
//
// Usage:
//   Input channel (s_valid/s_ready): one instruction word with the status
//   flags and the register-held jump target per item.
//   Result channel (m_valid/m_ready): ALU code, mux selects, register-file
//   and memory strobes, register numbers, immediate and the updated program
//   counter for that instruction.
//   Path: an accepted item passes through the input register, then the
//   result register, before it appears on the result ports.
//   Throughput: one item per cycle when the receiver keeps m_ready high;
//   the counter update, two adds and a three-way select, is combinational
//   decode logic between the two registers.
//   Reset (aresetn low at a rising edge): both pipeline registers empty and
//   the program counter goes to zero.
//   Stall: with m_ready low the result register holds its item; the input
//   register still takes one more item, after which s_ready drops until the
//   result is taken.
//   The counter is PC_WIDTH bits and wraps; m_next_pc shows its low 16 bits,
//   zero-extended when PC_WIDTH is below 16.
module risc16_decode_branch_control #(
    parameter int PC_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_instruction,
    input  logic [3:0]  s_status_flags,
    input  logic [15:0] s_target_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_alu_code,
    output logic [3:0]  m_mux_selects,
    output logic        m_reg_write,
    output logic        m_reg_read,
    output logic        m_mem_read,
    output logic        m_mem_write,
    output logic [3:0]  m_source_reg,
    output logic [3:0]  m_dest_reg,
    output logic [7:0]  m_immediate,
    output logic [15:0] m_next_pc
);

    localparam int EXT_WIDTH = (PC_WIDTH > 16) ? PC_WIDTH : 16;

    logic                  in_valid_reg;
    logic [15:0]           ins_reg;
    logic [3:0]            flags_reg;
    logic [15:0]           tgt_reg;
    logic                  out_valid_reg;
    logic [PC_WIDTH-1:0]   pc_reg;
    logic [PC_WIDTH-1:0]   pc_next;
    logic [PC_WIDTH-1:0]   pc_inc;
    logic [PC_WIDTH-1:0]   pc_disp;
    logic [PC_WIDTH-1:0]   pc_tgt;
    logic [EXT_WIDTH-1:0]  tgt_ext;
    logic [EXT_WIDTH-1:0]  pc_ext;
    logic                  advance;
    r16dbc_pkg::dec_ctrl_t ctrl;

    logic [5:0]  alu_code_reg;
    logic [3:0]  mux_selects_reg;
    logic        reg_write_reg;
    logic        reg_read_reg;
    logic        mem_read_reg;
    logic        mem_write_reg;
    logic [3:0]  source_reg_reg;
    logic [3:0]  dest_reg_reg;
    logic [7:0]  immediate_reg;
    logic [15:0] next_pc_reg;

    // Move the held instruction into the result register when it is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    r16dbc_decode u_decode (
        .instruction  (ins_reg),
        .status_flags (flags_reg),
        .ctrl         (ctrl)
    );

    assign tgt_ext = EXT_WIDTH'(tgt_reg);
    assign pc_tgt  = tgt_ext[PC_WIDTH-1:0];
    assign pc_inc  = pc_reg + PC_WIDTH'(1);
    // Bcond displacement is relative to the current counter, zero-extended
    assign pc_disp = pc_reg + PC_WIDTH'(ins_reg[7:0]);

    always_comb begin
        case (ctrl.pc_sel)
            r16dbc_pkg::PC_SEL_INC:  pc_next = pc_inc;
            r16dbc_pkg::PC_SEL_DISP: pc_next = pc_disp;
            r16dbc_pkg::PC_SEL_TGT:  pc_next = pc_tgt;
            default:                 pc_next = pc_inc;
        endcase
    end

    assign pc_ext = EXT_WIDTH'(pc_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                pc_reg        <= pc_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ins_reg   <= s_instruction;
            flags_reg <= s_status_flags;
            tgt_reg   <= s_target_address;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            alu_code_reg    <= ctrl.alu_code;
            mux_selects_reg <= ctrl.mux_selects;
            reg_write_reg   <= ctrl.reg_write;
            reg_read_reg    <= ctrl.reg_read;
            mem_read_reg    <= ctrl.mem_read;
            mem_write_reg   <= ctrl.mem_write;
            source_reg_reg  <= ins_reg[3:0];
            dest_reg_reg    <= ins_reg[11:8];
            immediate_reg   <= ins_reg[7:0];
            next_pc_reg     <= pc_ext[15:0];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_alu_code    = alu_code_reg;
    assign m_mux_selects = mux_selects_reg;
    assign m_reg_write   = reg_write_reg;
    assign m_reg_read    = reg_read_reg;
    assign m_mem_read    = mem_read_reg;
    assign m_mem_write   = mem_write_reg;
    assign m_source_reg  = source_reg_reg;
    assign m_dest_reg    = dest_reg_reg;
    assign m_immediate   = immediate_reg;
    assign m_next_pc     = next_pc_reg;

endmodule

// File: design/r16dbc_checker.sv
// Port-level checks for the decode and branch control block.
// Uses r16dbc_pkg; bound to risc16_decode_branch_control below.
module r16dbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_alu_code,
    input logic [3:0]  m_mux_selects,
    input logic        m_reg_write,
    input logic        m_reg_read,
    input logic        m_mem_read,
    input logic        m_mem_write,
    input logic [15:0] m_next_pc
);

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result holds its counter value
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_pc) && $stable(m_alu_code))
        else $error("stalled result changed");

    // Undefined encodings and NOP carry no strobes or selects
    a_quiet_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_alu_code == r16dbc_pkg::ALU_NONE ||
                    m_alu_code == r16dbc_pkg::ALU_NOP)
        |-> m_mux_selects == 4'b0000 && !m_reg_write && !m_reg_read &&
            !m_mem_read && !m_mem_write)
        else $error("strobe set on NOP or undefined item");

    // Memory strobes only with the load and store codes
    a_mem_strobes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_mem_read || m_mem_write)
        |-> (m_mem_read && m_alu_code == r16dbc_pkg::ALU_LOAD && !m_mem_write) ||
            (m_mem_write && m_alu_code == r16dbc_pkg::ALU_STOR && !m_mem_read))
        else $error("memory strobe on wrong item");

endmodule

bind risc16_decode_branch_control r16dbc_checker u_r16dbc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_alu_code    (m_alu_code),
    .m_mux_selects (m_mux_selects),
    .m_reg_write   (m_reg_write),
    .m_reg_read    (m_reg_read),
    .m_mem_read    (m_mem_read),
    .m_mem_write   (m_mem_write),
    .m_next_pc     (m_next_pc)
);

// File: test/tb_risc16_decode_branch_control.sv
// Testbench for risc16_decode_branch_control: directed and random instruction streams
// checked against an in-bench decoder and program-counter model.
// Depends on r16dbc_pkg and the risc16_decode_branch_control RTL.
module tb_risc16_decode_branch_control;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CHUNK_ITEMS = 200;

    // status flag bits
    localparam logic [3:0] FL_Z = 4'b1000;
    localparam logic [3:0] FL_N = 4'b0010;
    localparam logic [3:0] FL_C = 4'b0001;

    typedef struct packed {
        logic [5:0]  alu_code;
        logic [3:0]  mux_selects;
        logic        reg_write;
        logic        reg_read;
        logic        mem_read;
        logic        mem_write;
        logic [3:0]  source_reg;
        logic [3:0]  dest_reg;
        logic [7:0]  immediate;
        logic [15:0] next_pc;
    } decoded_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_instruction;
    logic [3:0]  s_status_flags;
    logic [15:0] s_target_address;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_alu_code;
    logic [3:0]  m_mux_selects;
    logic        m_reg_write;
    logic        m_reg_read;
    logic        m_mem_read;
    logic        m_mem_write;
    logic [3:0]  m_source_reg;
    logic [3:0]  m_dest_reg;
    logic [7:0]  m_immediate;
    logic [15:0] m_next_pc;

    decoded_t    pending_decodes[$];
    logic [15:0] pc_track;
    int          fail_count;
    int          cycle_count;
    bit          quiet;
    int          holdoff_req;
    int          rx_stall_left;

    risc16_decode_branch_control uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_instruction    (s_instruction),
        .s_status_flags   (s_status_flags),
        .s_target_address (s_target_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_alu_code       (m_alu_code),
        .m_mux_selects    (m_mux_selects),
        .m_reg_write      (m_reg_write),
        .m_reg_read       (m_reg_read),
        .m_mem_read       (m_mem_read),
        .m_mem_write      (m_mem_write),
        .m_source_reg     (m_source_reg),
        .m_dest_reg       (m_dest_reg),
        .m_immediate      (m_immediate),
        .m_next_pc        (m_next_pc)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic cond_met(input logic [3:0] cc, input logic [3:0] fl,
                                      output logic known);
        logic z, n, c;
        z = fl[3];
        n = fl[1];
        c = fl[0];
        known = 1'b1;
        case (cc)
            r16dbc_pkg::CC_EQ: return z;
            r16dbc_pkg::CC_NE: return !z;
            r16dbc_pkg::CC_CS: return c;
            r16dbc_pkg::CC_CC: return !c;
            r16dbc_pkg::CC_GT: return n;
            r16dbc_pkg::CC_LE: return !n;
            r16dbc_pkg::CC_LT: return !n && !z;
            r16dbc_pkg::CC_GE: return z || n;
            default: begin
                known = 1'b0;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic logic [5:0] cond_rank(input logic [3:0] cc);
        case (cc)
            r16dbc_pkg::CC_EQ: return {3'b000, r16dbc_pkg::RANK_EQ};
            r16dbc_pkg::CC_NE: return {3'b000, r16dbc_pkg::RANK_NE};
            r16dbc_pkg::CC_GE: return {3'b000, r16dbc_pkg::RANK_GE};
            r16dbc_pkg::CC_CS: return {3'b000, r16dbc_pkg::RANK_CS};
            r16dbc_pkg::CC_CC: return {3'b000, r16dbc_pkg::RANK_CC};
            r16dbc_pkg::CC_GT: return {3'b000, r16dbc_pkg::RANK_GT};
            r16dbc_pkg::CC_LE: return {3'b000, r16dbc_pkg::RANK_LE};
            default:           return {3'b000, r16dbc_pkg::RANK_LT};
        endcase
    endfunction

    // Decode one instruction and work out the counter that follows pc.
    function automatic decoded_t decode_instr(input logic [15:0] ins, input logic [3:0] fl,
                                              input logic [15:0] tgt, input logic [15:0] pc);
        decoded_t   d;
        logic [3:0] op, cc, ext, m1;
        logic [2:0] sh;
        logic       taken, known;
        op = ins[15:12];
        cc = ins[11:8];
        ext = ins[7:4];
        sh = ins[7:5];
        m1 = ins[7] ? 4'b0000 : r16dbc_pkg::MUX_M1;
        d = '0;
        d.source_reg = ins[3:0];
        d.dest_reg = cc;
        d.immediate = ins[7:0];
        d.next_pc = pc + 16'd1;
        taken = cond_met(cc, fl, known);
        if (ins == 16'h0000) begin
            d.alu_code = r16dbc_pkg::ALU_NOP;
        end else begin
            case (op)
                r16dbc_pkg::OP_REG: begin
                    d.reg_write = 1'b1;
                    d.reg_read = 1'b1;
                    d.mux_selects = r16dbc_pkg::MUX_M2 | r16dbc_pkg::MUX_M3;
                    case (ext)
                        r16dbc_pkg::EXT_ADD: d.alu_code = r16dbc_pkg::ALU_ADD;
                        r16dbc_pkg::EXT_SUB: d.alu_code = r16dbc_pkg::ALU_SUB;
                        r16dbc_pkg::EXT_AND: d.alu_code = r16dbc_pkg::ALU_AND;
                        r16dbc_pkg::EXT_OR:  d.alu_code = r16dbc_pkg::ALU_OR;
                        r16dbc_pkg::EXT_XOR: d.alu_code = r16dbc_pkg::ALU_XOR;
                        r16dbc_pkg::EXT_MOV: d.alu_code = r16dbc_pkg::ALU_MOV;
                        r16dbc_pkg::EXT_CMP: begin
                            d.alu_code = r16dbc_pkg::ALU_CMP;
                            d.reg_write = 1'b0;
                        end
                        default: begin
                            d.reg_write = 1'b0;
                            d.reg_read = 1'b0;
                            d.mux_selects = 4'b0000;
                        end
                    endcase
                end
                r16dbc_pkg::OP_ADDI, r16dbc_pkg::OP_SUBI, r16dbc_pkg::OP_ANDI,
                r16dbc_pkg::OP_CMPI, r16dbc_pkg::OP_ORI, r16dbc_pkg::OP_XORI,
                r16dbc_pkg::OP_MOVI: begin
                    d.reg_write = (op != r16dbc_pkg::OP_CMPI);
                    d.reg_read = 1'b1;
                    d.mux_selects = m1 | r16dbc_pkg::MUX_M3 |
                        ((op == r16dbc_pkg::OP_ORI || op == r16dbc_pkg::OP_XORI ||
                          op == r16dbc_pkg::OP_MOVI) ? r16dbc_pkg::MUX_M4 : 4'b0000);
                    case (op)
                        r16dbc_pkg::OP_ADDI: d.alu_code = r16dbc_pkg::ALU_ADDI;
                        r16dbc_pkg::OP_SUBI: d.alu_code = r16dbc_pkg::ALU_SUBI;
                        r16dbc_pkg::OP_ANDI: d.alu_code = r16dbc_pkg::ALU_ANDI;
                        r16dbc_pkg::OP_CMPI: d.alu_code = r16dbc_pkg::ALU_CMPI;
                        r16dbc_pkg::OP_ORI:  d.alu_code = r16dbc_pkg::ALU_ORI;
                        r16dbc_pkg::OP_XORI: d.alu_code = r16dbc_pkg::ALU_XORI;
                        default:             d.alu_code = r16dbc_pkg::ALU_MOVI;
                    endcase
                end
                r16dbc_pkg::OP_SHIFT: begin
                    case (sh)
                        r16dbc_pkg::SH_LSHI:  d.alu_code = r16dbc_pkg::ALU_LSHI;
                        r16dbc_pkg::SH_ASHUI: d.alu_code = r16dbc_pkg::ALU_ASHUI;
                        r16dbc_pkg::SH_LSH:   d.alu_code = r16dbc_pkg::ALU_LSH;
                        r16dbc_pkg::SH_ASHU:  d.alu_code = r16dbc_pkg::ALU_ASHU;
                        default:              d.alu_code = r16dbc_pkg::ALU_NONE;
                    endcase
                    if (d.alu_code != r16dbc_pkg::ALU_NONE) begin
                        d.reg_write = 1'b1;
                        d.reg_read = 1'b1;
                        d.mux_selects = m1 | r16dbc_pkg::MUX_M3 | r16dbc_pkg::MUX_M4 |
                            ((sh == r16dbc_pkg::SH_LSH || sh == r16dbc_pkg::SH_ASHU) ?
                             r16dbc_pkg::MUX_M2 : 4'b0000);
                    end
                end
                r16dbc_pkg::OP_MEM: begin
                    case (ext)
                        r16dbc_pkg::EXT_LOAD: begin
                            d.alu_code = r16dbc_pkg::ALU_LOAD;
                            d.reg_write = 1'b1;
                            d.mem_read = 1'b1;
                            d.mux_selects = m1 | r16dbc_pkg::MUX_M2;
                        end
                        r16dbc_pkg::EXT_STOR: begin
                            d.alu_code = r16dbc_pkg::ALU_STOR;
                            d.reg_read = 1'b1;
                            d.mem_write = 1'b1;
                            d.mux_selects = m1 | r16dbc_pkg::MUX_M2;
                        end
                        r16dbc_pkg::EXT_JAL: begin
                            d.alu_code = r16dbc_pkg::ALU_JAL;
                            d.reg_write = 1'b1;
                            d.reg_read = 1'b1;
                            d.mux_selects = m1 | r16dbc_pkg::MUX_M2;
                            d.next_pc = tgt;
                        end
                        r16dbc_pkg::EXT_JCOND: begin
                            if (known) begin
                                d.alu_code = r16dbc_pkg::ALU_JCOND_BASE + cond_rank(cc);
                                d.reg_read = 1'b1;
                                if (taken)
                                    d.next_pc = tgt;
                            end
                        end
                        default: ;
                    endcase
                end
                r16dbc_pkg::OP_BCOND: begin
                    if (known) begin
                        d.alu_code = r16dbc_pkg::ALU_BCOND_BASE + cond_rank(cc);
                        if (taken)
                            d.next_pc = pc + {8'h00, ins[7:0]};
                    end
                end
                r16dbc_pkg::OP_LUI: begin
                    d.alu_code = r16dbc_pkg::ALU_LUI;
                    d.reg_write = 1'b1;
                    d.mux_selects = r16dbc_pkg::MUX_M1 | r16dbc_pkg::MUX_M3 |
                                    r16dbc_pkg::MUX_M4;
                end
                default: ;
            endcase
        end
        return d;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [3:0] random_cond();
        logic [3:0] cc;
        cc = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 8))
            0: cc = r16dbc_pkg::CC_EQ;
            1: cc = r16dbc_pkg::CC_NE;
            2: cc = r16dbc_pkg::CC_CS;
            3: cc = r16dbc_pkg::CC_CC;
            4: cc = r16dbc_pkg::CC_GT;
            5: cc = r16dbc_pkg::CC_LE;
            6: cc = r16dbc_pkg::CC_LT;
            7: cc = r16dbc_pkg::CC_GE;
            default: ;
        endcase
        return cc;
    endfunction

    // Mostly well-formed encodings with random fields, some raw noise words.
    function automatic logic [15:0] random_instr();
        logic [15:0] word;
        logic [3:0]  op, cc, ext, src;
        logic [7:0]  imm;
        int          pick;
        pick = $urandom_range(0, 99);
        word = 16'($urandom);
        cc = 4'($urandom_range(0, 15));
        ext = 4'($urandom_range(0, 15));
        src = 4'($urandom_range(0, 15));
        imm = 8'($urandom_range(0, 255));
        op = r16dbc_pkg::OP_MOVI;
        if (pick < 6)
            return word;
        if (pick < 10)
            return 16'h0000;
        if (pick < 28) begin
            case ($urandom_range(0, 7))
                0: ext = r16dbc_pkg::EXT_ADD;
                1: ext = r16dbc_pkg::EXT_SUB;
                2: ext = r16dbc_pkg::EXT_AND;
                3: ext = r16dbc_pkg::EXT_OR;
                4: ext = r16dbc_pkg::EXT_XOR;
                5: ext = r16dbc_pkg::EXT_CMP;
                6: ext = r16dbc_pkg::EXT_MOV;
                default: ;
            endcase
            return {r16dbc_pkg::OP_REG, cc, ext, src};
        end
        if (pick < 46) begin
            case ($urandom_range(0, 6))
                0: op = r16dbc_pkg::OP_ADDI;
                1: op = r16dbc_pkg::OP_SUBI;
                2: op = r16dbc_pkg::OP_ANDI;
                3: op = r16dbc_pkg::OP_CMPI;
                4: op = r16dbc_pkg::OP_ORI;
                5: op = r16dbc_pkg::OP_XORI;
                default: ;
            endcase
            return {op, cc, imm};
        end
        if (pick < 56) begin
            // keep most shift ops in the defined range
            if ($urandom_range(0, 4) != 0)
                imm[7] = 1'b0;
            return {r16dbc_pkg::OP_SHIFT, cc, imm};
        end
        if (pick < 70) begin
            case ($urandom_range(0, 4))
                0: ext = r16dbc_pkg::EXT_LOAD;
                1: ext = r16dbc_pkg::EXT_STOR;
                2: ext = r16dbc_pkg::EXT_JAL;
                3: ext = r16dbc_pkg::EXT_JCOND;
                default: ;
            endcase
            return {r16dbc_pkg::OP_MEM, cc, ext, src};
        end
        if (pick < 80)
            return {r16dbc_pkg::OP_MEM, random_cond(), r16dbc_pkg::EXT_JCOND, src};
        if (pick < 94)
            return {r16dbc_pkg::OP_BCOND, random_cond(), imm};
        return {r16dbc_pkg::OP_LUI, cc, imm};
    endfunction

    // Offer one item after an optional gap; return at the edge that takes it.
    task automatic send_instr(input logic [15:0] ins, input logic [3:0] fl,
                              input logic [15:0] tgt);
        int       gap;
        decoded_t d;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_instruction <= ins;
        s_status_flags <= fl;
        s_target_address <= tgt;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        d = decode_instr(ins, fl, tgt, pc_track);
        pc_track = d.next_pc;
        pending_decodes.push_back(d);
    endtask

    task automatic send_random();
        logic [15:0] tgt;
        tgt = 16'($urandom);
        case ($urandom_range(0, 19))
            0: tgt = 16'h0000;
            1: tgt = 16'hFFFF;
            default: ;
        endcase
        send_instr(random_instr(), 4'($urandom_range(0, 15)), tgt);
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed();
        send_instr(16'h0000, 4'hF, 16'hFFFF);             // NOP word
        send_instr(16'h0352, 4'h0, 16'h0000);             // ADD
        send_instr(16'h0FBF, 4'hF, 16'h1234);             // CMP
        send_instr(16'h0A7A, 4'h5, 16'h0000);             // undefined op extension
        send_instr(16'h1A7F, 4'h0, 16'h0000);             // ANDI, immediate bit 7 clear
        send_instr(16'h2580, 4'h0, 16'h0000);             // ORI, immediate bit 7 set
        send_instr(16'hB3FF, 4'hA, 16'h0000);             // CMPI
        send_instr(16'hD000, 4'h0, 16'h0000);             // MOVI
        send_instr(16'h8105, 4'h0, 16'h0000);             // LSHI
        send_instr(16'h8F6F, 4'h0, 16'h0000);             // ASHU
        send_instr(16'h81E3, 4'h0, 16'h0000);             // undefined shift op
        send_instr(16'h4203, 4'h0, 16'h0000);             // LOAD
        send_instr(16'h4A4F, 4'h0, 16'h0000);             // STOR
        send_instr(16'h4E8A, 4'h0, 16'hFFFF);             // JAL to the top of the counter
        send_instr(16'hF1AB, 4'h0, 16'h5555);             // LUI advances and wraps
        send_instr(16'h40C5, FL_Z, 16'hFFF0);             // Jcond EQ taken
        send_instr(16'hCDFF, FL_Z, 16'h0000);             // Bcond GE taken, wraps
        send_instr(16'hCC10, FL_N, 16'h0000);             // Bcond LT not taken
        send_instr(16'h41C0, FL_Z, 16'hAAAA);             // Jcond NE not taken
        send_instr(16'hC520, 4'hF, 16'h0000);             // Bcond undefined condition
        send_instr(16'h4FC0, 4'hF, 16'hFFFF);             // Jcond undefined condition
        send_instr(16'h4312, FL_C, 16'hFFFF);             // undefined memory extension
        send_instr(16'h7FFF, 4'hF, 16'hFFFF);             // undefined opcode
        send_instr(16'hE000, 4'h0, 16'h0000);             // undefined opcode
        send_instr(16'hFFFF, 4'hF, 16'hFFFF);             // LUI, all ones
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while items keep coming.
    task automatic test_backpressure();
        quiet = 1'b1;
        holdoff_req = 300;
        repeat (40) send_random();
        quiet = 1'b0;
        wait_drained();
    endtask

    // Pause the sender until the block is empty, then resume.
    task automatic test_drain_pause();
        repeat (30) send_random();
        wait_drained();
        repeat (30) send_random();
        wait_drained();
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // every third chunk runs without idling on either side
            quiet = ((i / CHUNK_ITEMS) % 3 == 2);
            send_random();
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    // Receiver: random stalls, plus any long hold-off a test asks for.
    always @(posedge aclk) begin
        if (holdoff_req > 0) begin
            rx_stall_left = holdoff_req;
            holdoff_req = 0;
        end
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else if (!quiet && $urandom_range(0, 99) < 22) begin
            m_ready <= 1'b0;
            rx_stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                         : $urandom_range(8, 40);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        decoded_t d;
        if (aresetn && m_valid && m_ready) begin
            if (pending_decodes.size() == 0) begin
                $error("result item arrived with nothing expected");
                fail_count++;
            end else begin
                d = pending_decodes.pop_front();
                check_field("alu_code", int'(d.alu_code), int'(m_alu_code));
                check_field("mux_selects", int'(d.mux_selects), int'(m_mux_selects));
                check_field("reg_write", int'(d.reg_write), int'(m_reg_write));
                check_field("reg_read", int'(d.reg_read), int'(m_reg_read));
                check_field("mem_read", int'(d.mem_read), int'(m_mem_read));
                check_field("mem_write", int'(d.mem_write), int'(m_mem_write));
                check_field("source_reg", int'(d.source_reg), int'(m_source_reg));
                check_field("dest_reg", int'(d.dest_reg), int'(m_dest_reg));
                check_field("immediate", int'(d.immediate), int'(m_immediate));
                check_field("next_pc", int'(d.next_pc), int'(m_next_pc));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        cycle_count = 0;
        quiet = 1'b0;
        holdoff_req = 0;
        rx_stall_left = 0;
        pc_track = 16'h0000;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_instruction <= 16'h0000;
        s_status_flags <= 4'h0;
        s_target_address <= 16'h0000;
        m_ready <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random_stream();

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_decodes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
